// File: src/pso_velocity_position_update_defines.svh
// assertion macros used by the checker file of the swarm update block
`ifndef PSO_VELOCITY_POSITION_UPDATE_DEFINES_SVH
`define PSO_VELOCITY_POSITION_UPDATE_DEFINES_SVH

// plain concurrent assertion, sampled on the rising clock
`define PVPU_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// concurrent assertion that is switched off while reset is high
`define PVPU_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: src/pvpu_pkg.sv
// shared types, constants and helpers of the swarm velocity and position update
package pvpu_pkg;

   // default sizes
   localparam int NUM_DIMS_DEF       = 54;
   localparam int NUM_JOINT_DIMS_DEF = 40;
   localparam int QUEUE_DEPTH_DEF    = 4;

   // register reset values
   localparam logic [15:0] INERTIA_RST = 16'd47831;  // 0.72984 in Q0.16
   localparam logic [15:0] GAIN_RST    = 16'd8397;   // 2.05 in Q4.12

   // register indexes
   typedef enum logic [1:0] {
      CSR_INERTIA   = 2'd0,
      CSR_COGNITIVE = 2'd1,
      CSR_SOCIAL    = 2'd2
   } csr_index_type;

   // operation codes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // joint bounds in Q16.16
   localparam logic signed [31:0] ABD_LO = -32'sd1966080;   // -30
   localparam logic signed [31:0] ABD_HI = 32'sd1966080;    //  30
   localparam logic signed [31:0] JNT_LO = -32'sd655360;    // -10
   localparam logic signed [31:0] JNT_HI = 32'sd6553600;    //  100

   // saturation limits
   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   // one queued word, classified by the front
   typedef struct packed {
      logic                op;
      logic [5:0]          dim;
      logic                dim_ok;
      logic                zero_neg;
      logic                zero_pos;
      logic signed [31:0]  cur;
      logic signed [31:0]  pbest;
      logic signed [31:0]  gbest;
      logic [15:0]         rand_c;
      logic [15:0]         rand_s;
   } entry_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [15:0] inertia;
      logic [15:0] cog;
      logic [15:0] soc;
   } gains_type;

   // abduction joint: (dim mod 20) mod 4 == 1, dim below 64
   function automatic logic is_abduction(input logic [5:0] dim);
      logic [5:0] rem;
      rem = dim;
      if (rem >= 6'd40) rem = rem - 6'd40;
      if (rem >= 6'd20) rem = rem - 6'd20;
      return rem[1:0] == 2'd1;
   endfunction

endpackage

// File: src/pvpu_front.sv
// front end: takes request words and classifies dimension and joint limits
module pvpu_front #(
   parameter int NUM_DIMS       = pvpu_pkg::NUM_DIMS_DEF,
   parameter int NUM_JOINT_DIMS = pvpu_pkg::NUM_JOINT_DIMS_DEF
) (
   input  logic                req_valid,
   input  logic                req_operation,
   input  logic [5:0]          req_dim_index,
   input  logic signed [31:0]  req_current_value,
   input  logic signed [31:0]  req_personal_best_value,
   input  logic signed [31:0]  req_global_best_value,
   input  logic [15:0]         req_rand_cognitive,
   input  logic [15:0]         req_rand_social,
   input  logic                queue_full,
   output logic                push,
   output pvpu_pkg::entry_type push_entry
);
   import pvpu_pkg::*;

   logic                dim_ok;
   logic                joint;
   logic                abd;
   logic signed [31:0]  lo_bound;
   logic signed [31:0]  hi_bound;

   // a word is taken whenever the queue has room
   assign push = req_valid && !queue_full;

   // dimension range and joint class
   always_comb begin
      dim_ok   = 9'(req_dim_index) < 9'(NUM_DIMS);
      joint    = dim_ok && (9'(req_dim_index) < 9'(NUM_JOINT_DIMS));
      abd      = is_abduction(req_dim_index);
      lo_bound = abd ? ABD_LO : JNT_LO;
      hi_bound = abd ? ABD_HI : JNT_HI;
   end

   // pack the classified word
   always_comb begin
      push_entry          = '0;
      push_entry.op       = req_operation;
      push_entry.dim      = req_dim_index;
      push_entry.dim_ok   = dim_ok;
      push_entry.zero_neg = joint && (req_current_value < lo_bound);
      push_entry.zero_pos = joint && (req_current_value > hi_bound);
      push_entry.cur      = req_current_value;
      push_entry.pbest    = req_personal_best_value;
      push_entry.gbest    = req_global_best_value;
      push_entry.rand_c   = req_rand_cognitive;
      push_entry.rand_s   = req_rand_social;
   end

endmodule

// File: src/pvpu_queue.sv
// short word queue between the front and the back end
module pvpu_queue #(
   parameter int DEPTH = pvpu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pvpu_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output pvpu_pkg::entry_type head,
   output logic                empty
);
   import pvpu_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   entry_type       slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full  = count_ff == CntW'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/pvpu_back.sv
// back end: attraction terms, constriction, velocity store and position
module pvpu_back #(
   parameter int NUM_DIMS = pvpu_pkg::NUM_DIMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pvpu_pkg::gains_type gains,
   input  logic                word_valid,
   input  pvpu_pkg::entry_type word,
   output logic                word_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_new_position,
   output logic signed [31:0]  rsp_new_velocity
);
   import pvpu_pkg::*;

   localparam int AddrW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

   typedef struct packed {
      logic               op;
      logic [5:0]         dim;
      logic               dim_ok;
      logic               zero_neg;
      logic               zero_pos;
      logic signed [31:0] cur;
   } tag_type;

   logic                adv;

   // stage 1: differences and gain times random
   logic                s1_valid_ff;
   tag_type             s1_tag_ff, s1_tag_in;
   logic signed [32:0]  s1_diff_p_ff, s1_diff_p_in;
   logic signed [32:0]  s1_diff_g_ff, s1_diff_g_in;
   logic [15:0]         s1_gr_c_ff, s1_gr_s_ff;
   logic [31:0]         gr_c_full, gr_s_full;

   // stage 2: attraction products
   logic                s2_valid_ff;
   tag_type             s2_tag_ff;
   logic signed [49:0]  s2_prod_p_ff, s2_prod_p_in;
   logic signed [49:0]  s2_prod_g_ff, s2_prod_g_in;

   // stage 3: rounded attraction sum
   logic signed [49:0]  rnd_p, rnd_g;
   logic                s3_valid_ff;
   tag_type             s3_tag_ff;
   logic signed [38:0]  s3_asum_ff, s3_asum_in;

   // stage 4: weighted attraction, old velocity
   logic                s4_valid_ff;
   tag_type             s4_tag_ff;
   logic signed [55:0]  s4_pterm_ff, s4_pterm_in;
   logic signed [31:0]  mem_q_ff;
   logic                vbit_q_ff;
   logic                fwd_ff, fwd_in;
   logic signed [31:0]  fwd_val_ff;
   logic signed [31:0]  vold;
   logic signed [48:0]  vterm;
   logic signed [56:0]  total, rtotal;
   logic signed [40:0]  vq;
   logic signed [31:0]  vsat, vnew;

   // stage 5 and output word
   logic                s5_valid_ff;
   tag_type             s5_tag_ff;
   logic signed [31:0]  s5_vel_ff;
   logic signed [32:0]  pos_sum;
   logic signed [31:0]  pos_in;
   logic                out_valid_ff;
   logic signed [31:0]  out_pos_ff, out_vel_ff;

   // velocity store
   logic signed [31:0]  vel_store_ff [NUM_DIMS];
   logic [NUM_DIMS-1:0] vbit_ff;
   logic                wr_en;
   logic [AddrW-1:0]    wr_addr, rd_addr;

   // the whole pipe moves unless the output word is held
   assign adv      = !out_valid_ff || !rsp_stall;
   assign word_pop = adv && word_valid;

   // stage 1 logic
   always_comb begin
      s1_tag_in.op       = word.op;
      s1_tag_in.dim      = word.dim;
      s1_tag_in.dim_ok   = word.dim_ok;
      s1_tag_in.zero_neg = word.zero_neg;
      s1_tag_in.zero_pos = word.zero_pos;
      s1_tag_in.cur      = word.cur;
      s1_diff_p_in = {word.pbest[31], word.pbest} - {word.cur[31], word.cur};
      s1_diff_g_in = {word.gbest[31], word.gbest} - {word.cur[31], word.cur};
      gr_c_full    = gains.cog * word.rand_c;
      gr_s_full    = gains.soc * word.rand_s;
   end

   // stage 2 logic
   assign s2_prod_p_in = $signed({1'b0, s1_gr_c_ff}) * s1_diff_p_ff;
   assign s2_prod_g_in = $signed({1'b0, s1_gr_s_ff}) * s1_diff_g_ff;

   // stage 3 logic: round half up to Q16.16, then add
   always_comb begin
      rnd_p      = s2_prod_p_ff + 50'sd2048;
      rnd_g      = s2_prod_g_ff + 50'sd2048;
      s3_asum_in = {rnd_p[49], rnd_p[49:12]} + {rnd_g[49], rnd_g[49:12]};
   end

   // stage 4 input: constriction on the attraction part
   assign s4_pterm_in = s3_asum_ff * $signed({1'b0, gains.inertia});

   // old velocity with bypass from the previous word's write to the same dimension
   assign fwd_in = s4_valid_ff && s4_tag_ff.dim_ok && (s4_tag_ff.dim == s3_tag_ff.dim);

   always_comb begin
      if (!s4_tag_ff.dim_ok) begin
         vold = '0;
      end else if (fwd_ff) begin
         vold = fwd_val_ff;
      end else if (vbit_q_ff) begin
         vold = mem_q_ff;
      end else begin
         vold = '0;
      end
   end

   // new velocity: weight, round, saturate, clear and joint limits
   always_comb begin
      vterm  = vold * $signed({1'b0, gains.inertia});
      total  = {s4_pterm_ff[55], s4_pterm_ff} + {{8{vterm[48]}}, vterm};
      rtotal = total + 57'sd32768;
      vq     = rtotal[56:16];
      if (vq[40:31] == {10{vq[40]}}) begin
         vsat = vq[31:0];
      end else begin
         vsat = vq[40] ? Q_MIN : Q_MAX;
      end
      if (s4_tag_ff.op == OP_CLEAR) begin
         vnew = '0;
      end else if (s4_tag_ff.zero_neg && vsat[31]) begin
         vnew = '0;
      end else if (s4_tag_ff.zero_pos && !vsat[31] && (vsat != '0)) begin
         vnew = '0;
      end else begin
         vnew = vsat;
      end
   end

   // store addressing
   assign wr_en   = adv && s4_valid_ff && s4_tag_ff.dim_ok;
   assign wr_addr = AddrW'(s4_tag_ff.dim);
   assign rd_addr = AddrW'(s3_tag_ff.dim);

   // position, saturated
   always_comb begin
      pos_sum = {s5_tag_ff.cur[31], s5_tag_ff.cur} + {s5_vel_ff[31], s5_vel_ff};
      if (pos_sum[32] != pos_sum[31]) begin
         pos_in = pos_sum[32] ? Q_MIN : Q_MAX;
      end else begin
         pos_in = pos_sum[31:0];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= word_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         out_valid_ff <= s5_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff    <= s1_tag_in;
         s1_diff_p_ff <= s1_diff_p_in;
         s1_diff_g_ff <= s1_diff_g_in;
         s1_gr_c_ff   <= gr_c_full[31:16];
         s1_gr_s_ff   <= gr_s_full[31:16];
         s2_tag_ff    <= s1_tag_ff;
         s2_prod_p_ff <= s2_prod_p_in;
         s2_prod_g_ff <= s2_prod_g_in;
         s3_tag_ff    <= s2_tag_ff;
         s3_asum_ff   <= s3_asum_in;
         s4_tag_ff    <= s3_tag_ff;
         s4_pterm_ff  <= s4_pterm_in;
         fwd_ff       <= fwd_in;
         fwd_val_ff   <= vnew;
         s5_tag_ff    <= s4_tag_ff;
         s5_vel_ff    <= vnew;
         out_pos_ff   <= pos_in;
         out_vel_ff   <= s5_vel_ff;
      end
   end

   // velocity memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vel_store_ff[wr_addr] <= vnew;
      end
      if (adv) begin
         mem_q_ff  <= vel_store_ff[rd_addr];
         vbit_q_ff <= vbit_ff[rd_addr];
      end
   end

   // written marks, an unmarked entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vbit_ff <= '0;
      end else if (wr_en) begin
         vbit_ff[wr_addr] <= 1'b1;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_new_position = out_pos_ff;
   assign rsp_new_velocity = out_vel_ff;

endmodule

// File: src/pso_velocity_position_update.sv
// top level of the particle swarm velocity and position update
// One word per dimension: update (or clear) that dimension's stored velocity
// and return the new position and velocity in Q16.16. The block sustains one
// word per clock while rsp_stall is low; a held result word stops the whole
// pipe. The velocity read, weight multiply and write-back of one dimension
// close in the last multiply stage, with a bypass for back-to-back words on
// the same dimension. A four-word queue sits between the front and the
// arithmetic pipe, so req_stall rises only once the result side has been held
// long enough to fill it. Configuration writes are always taken (csr_ready
// high) and must be made while no word is in flight; registers reset to
// w = 0.72984 and both gains = 2.05. The velocity store reads as zero after
// reset with no clearing pass.
module pso_velocity_position_update #(
   parameter int NUM_DIMS       = pvpu_pkg::NUM_DIMS_DEF,
   parameter int NUM_JOINT_DIMS = pvpu_pkg::NUM_JOINT_DIMS_DEF,
   parameter int QUEUE_DEPTH    = pvpu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic [5:0]          req_dim_index,
   input  logic signed [31:0]  req_current_value,
   input  logic signed [31:0]  req_personal_best_value,
   input  logic signed [31:0]  req_global_best_value,
   input  logic [15:0]         req_rand_cognitive,
   input  logic [15:0]         req_rand_social,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_new_position,
   output logic signed [31:0]  rsp_new_velocity,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import pvpu_pkg::*;

   gains_type gains_ff, gains_in;
   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      queue_empty;
   logic      queue_pop;
   entry_type queue_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INERTIA:   gains_in.inertia = csr_wdata;
            CSR_COGNITIVE: gains_in.cog     = csr_wdata;
            CSR_SOCIAL:    gains_in.soc     = csr_wdata;
            default:       gains_in         = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.inertia <= INERTIA_RST;
         gains_ff.cog     <= GAIN_RST;
         gains_ff.soc     <= GAIN_RST;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign req_stall = queue_full;

   // front end
   pvpu_front #(
      .NUM_DIMS       (NUM_DIMS),
      .NUM_JOINT_DIMS (NUM_JOINT_DIMS)
   ) u_front (
      .req_valid               (req_valid),
      .req_operation           (req_operation),
      .req_dim_index           (req_dim_index),
      .req_current_value       (req_current_value),
      .req_personal_best_value (req_personal_best_value),
      .req_global_best_value   (req_global_best_value),
      .req_rand_cognitive      (req_rand_cognitive),
      .req_rand_social         (req_rand_social),
      .queue_full              (queue_full),
      .push                    (push),
      .push_entry              (push_entry)
   );

   // word queue
   pvpu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head       (queue_head),
      .empty      (queue_empty)
   );

   // arithmetic back end
   pvpu_back #(
      .NUM_DIMS (NUM_DIMS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .gains            (gains_ff),
      .word_valid       (!queue_empty),
      .word             (queue_head),
      .word_pop         (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_position (rsp_new_position),
      .rsp_new_velocity (rsp_new_velocity)
   );

endmodule

// File: src/pvpu_checker.sv
// port checker of the swarm update block and its bind
`include "pso_velocity_position_update_defines.svh"

module pvpu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_new_position,
   input logic [31:0] rsp_new_velocity
);

   // after reset nothing is pending and the queue has room
   `PVPU_ASSERT(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall, "not idle after reset")

   // a held result word stays offered
   `PVPU_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp word dropped")

   // a held result word keeps its payload
   `PVPU_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_new_position) && $stable(rsp_new_velocity), "rsp payload moved")

   // the queue only fills behind a held result word
   `PVPU_ASSERT_RST(a_stall_cause, clock, reset, req_stall |-> $past(rsp_valid && rsp_stall), "req stall without rsp backpressure")

endmodule

bind pso_velocity_position_update pvpu_checker u_checker (.*);

// File: sim/tb.sv
// self-checking testbench for the swarm velocity and position update block
`timescale 1ns / 1ps

module tb;
   import pvpu_pkg::*;

   localparam int Q_ONE       = 65536;
   localparam int WATCH_MAX   = 2000;
   localparam int PHASE_WORDS = 210;
   localparam int NUM_PHASES  = 8;
   localparam int SHOW_MAX    = 10;
   localparam int IDLE_HEAVY  = 85;
   localparam int IDLE_LIGHT  = 8;

   // one request word and one result word
   typedef struct {
      logic               op;
      logic [5:0]         dim;
      logic signed [31:0] cur;
      logic signed [31:0] pbest;
      logic signed [31:0] gbest;
      logic [15:0]        rand_c;
      logic [15:0]        rand_s;
   } swarm_word;

   typedef struct {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
   } move_word;

   typedef struct {
      swarm_word w;
      bit        typed;
      move_word  m;
   } stim_row;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_operation;
   logic [5:0]         req_dim_index;
   logic signed [31:0] req_current_value;
   logic signed [31:0] req_personal_best_value;
   logic signed [31:0] req_global_best_value;
   logic [15:0]        req_rand_cognitive;
   logic [15:0]        req_rand_social;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_new_position;
   logic signed [31:0] rsp_new_velocity;
   logic               csr_valid;
   logic               csr_ready;
   csr_index_type      csr_index;
   logic [15:0]        csr_wdata;

   // predictor state
   logic signed [31:0] vel_mem [NUM_DIMS_DEF];
   logic [15:0]        w_reg;
   logic [15:0]        cog_reg;
   logic [15:0]        soc_reg;

   move_word pending_moves [$];
   stim_row  directed_rows [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;
   int n_errors      = 0;
   int n_checked     = 0;
   int n_words       = 0;
   int n_clears      = 0;
   int n_cuts        = 0;

   pso_velocity_position_update dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_operation           (req_operation),
      .req_dim_index           (req_dim_index),
      .req_current_value       (req_current_value),
      .req_personal_best_value (req_personal_best_value),
      .req_global_best_value   (req_global_best_value),
      .req_rand_cognitive      (req_rand_cognitive),
      .req_rand_social         (req_rand_social),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_new_position        (rsp_new_position),
      .rsp_new_velocity        (rsp_new_velocity),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always #5 clock = ~clock;

   // saturate to signed 32 bits
   function automatic longint clip32(longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
   endfunction

   // gain times random, floored to q4.12, times the difference, rounded to q16.16
   function automatic longint pull(logic [15:0] gain, logic [15:0] rnd, longint diff);
      longint gr;
      gr = (longint'(gain) * longint'(rnd)) >>> 16;
      return (gr * diff + 2048) >>> 12;
   endfunction

   // expected position and velocity for one word, updating the velocity copy
   function automatic move_word swarm_step(swarm_word w);
      move_word m;
      longint   cur;
      longint   vold;
      longint   sum;
      longint   vnew;
      longint   lo;
      longint   hi;
      bit       in_store;
      cur = longint'(w.cur);
      in_store = w.dim < NUM_DIMS_DEF;
      if (w.op == OP_CLEAR) begin
         if (in_store) vel_mem[w.dim] = '0;
         m.pos = w.cur;
         m.vel = '0;
         n_clears++;
         return m;
      end
      vold = in_store ? longint'(vel_mem[w.dim]) : 0;
      sum = vold + pull(cog_reg, w.rand_c, longint'(w.pbest) - cur)
                 + pull(soc_reg, w.rand_s, longint'(w.gbest) - cur);
      vnew = clip32((sum * longint'(w_reg) + 32768) >>> 16);
      // joint angles outside their range stop moving further out
      if (in_store && w.dim < NUM_JOINT_DIMS_DEF) begin
         if (((w.dim % 20) % 4) == 1) begin
            lo = longint'(ABD_LO);
            hi = longint'(ABD_HI);
         end else begin
            lo = longint'(JNT_LO);
            hi = longint'(JNT_HI);
         end
         if ((cur < lo && vnew < 0) || (cur > hi && vnew > 0)) begin
            vnew = 0;
            n_cuts++;
         end
      end
      if (in_store) vel_mem[w.dim] = 32'(vnew);
      m.vel = 32'(vnew);
      m.pos = 32'(clip32(cur + vnew));
      return m;
   endfunction

   task automatic add_row(logic op, logic [5:0] dim, logic signed [31:0] cur, pb, gb,
                          logic [15:0] rc, rs, bit typed, logic signed [31:0] epos, evel);
      stim_row r;
      r.w = '{op, dim, cur, pb, gb, rc, rs};
      r.typed = typed;
      r.m = '{epos, evel};
      directed_rows.push_back(r);
   endtask

   // mostly well-formed updates around the joint ranges, some clears and raw noise
   function automatic swarm_word random_word();
      swarm_word w;
      int        pick;
      int        center;
      pick = $urandom_range(99);
      w.rand_c = 16'($urandom);
      w.rand_s = 16'($urandom);
      if (pick < 80) begin
         center = int'($urandom_range(300 * Q_ONE)) - 150 * Q_ONE;
         w.op = OP_UPDATE;
         w.dim = 6'($urandom_range(NUM_DIMS_DEF - 1));
         w.cur = center;
         w.pbest = center + int'($urandom_range(40 * Q_ONE)) - 20 * Q_ONE;
         w.gbest = center + int'($urandom_range(40 * Q_ONE)) - 20 * Q_ONE;
      end else if (pick < 90) begin
         w.op = OP_CLEAR;
         w.dim = 6'($urandom_range(63));
         w.cur = $urandom;
         w.pbest = $urandom;
         w.gbest = $urandom;
      end else begin
         w.op = 1'($urandom);
         w.dim = 6'($urandom);
         w.cur = $urandom;
         w.pbest = $urandom;
         w.gbest = $urandom;
      end
      return w;
   endfunction

   // drive one word from a falling edge and record its expected result
   task automatic send_word(swarm_word w, bit typed, move_word typed_m);
      move_word m;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = w.op;
      req_dim_index = w.dim;
      req_current_value = w.cur;
      req_personal_best_value = w.pbest;
      req_global_best_value = w.gbest;
      req_rand_cognitive = w.rand_c;
      req_rand_social = w.rand_s;
      do @(posedge clock); while (req_stall);
      m = swarm_step(w);
      pending_moves.push_back(typed ? typed_m : m);
      n_words++;
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INERTIA:   w_reg = val;
         CSR_COGNITIVE: cog_reg = val;
         default:       soc_reg = val;
      endcase
      @(negedge clock);
   endtask

   // hold off the sender until every result is back, then let the pipe settle
   task automatic drain();
      req_valid = 1'b0;
      while (pending_moves.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      move_word want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         if (pending_moves.size() == 0) begin
            n_errors++;
            if (n_errors <= SHOW_MAX)
               $display("unexpected result word: position %h velocity %h",
                        rsp_new_position, rsp_new_velocity);
         end else begin
            want = pending_moves.pop_front();
            if (rsp_new_position !== want.pos) begin
               n_errors++;
               if (n_errors <= SHOW_MAX)
                  $display("result %0d position: expected %h actual %h",
                           n_checked, want.pos, rsp_new_position);
            end
            if (rsp_new_velocity !== want.vel) begin
               n_errors++;
               if (n_errors <= SHOW_MAX)
                  $display("result %0d velocity: expected %h actual %h",
                           n_checked, want.vel, rsp_new_velocity);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_MAX) begin
         $display("watchdog: no handshake for %0d cycles, %0d results pending",
                  WATCH_MAX, pending_moves.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      move_word    no_move;
      logic [15:0] gain_set [NUM_PHASES][3];
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_UPDATE;
      req_dim_index = '0;
      req_current_value = '0;
      req_personal_best_value = '0;
      req_global_best_value = '0;
      req_rand_cognitive = '0;
      req_rand_social = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_INERTIA;
      csr_wdata = '0;
      no_move = '{'0, '0};
      w_reg = INERTIA_RST;
      cog_reg = GAIN_RST;
      soc_reg = GAIN_RST;
      foreach (vel_mem[i]) vel_mem[i] = '0;

      // register settings per phase, extremes among them
      gain_set[0] = '{INERTIA_RST, GAIN_RST, GAIN_RST};
      gain_set[1] = '{16'h0000, 16'h0000, 16'h0000};
      gain_set[2] = '{16'hffff, 16'hffff, 16'hffff};
      gain_set[3] = '{16'($urandom), 16'($urandom), 16'($urandom)};
      gain_set[4] = '{16'hffff, 16'h0000, 16'hffff};
      gain_set[5] = '{16'h0000, 16'hffff, 16'h0000};
      gain_set[6] = '{16'($urandom), 16'($urandom), 16'($urandom)};
      gain_set[7] = '{16'h8000, 16'h1000, 16'h1000};

      // directed words at reset gains
      // clear then a zero-pull update give zero velocity
      add_row(OP_CLEAR, 0, 5 * Q_ONE, 0, 0, 0, 0, 1, 5 * Q_ONE, 0);
      add_row(OP_UPDATE, 0, Q_ONE, Q_ONE, Q_ONE, 16'hffff, 16'hffff, 1, Q_ONE, 0);
      // joints past a bound and pulled further out are stopped
      add_row(OP_UPDATE, 1, ABD_HI + 1, ABD_HI + 5 * Q_ONE, ABD_HI + 5 * Q_ONE,
              16'hffff, 16'hffff, 1, ABD_HI + 1, 0);
      add_row(OP_UPDATE, 2, JNT_LO - 1, JNT_LO - 5 * Q_ONE, JNT_LO - 5 * Q_ONE,
              16'hffff, 16'hffff, 1, JNT_LO - 1, 0);
      add_row(OP_UPDATE, 21, ABD_LO - 1, ABD_LO - 5 * Q_ONE, ABD_LO - 5 * Q_ONE,
              16'hffff, 16'hffff, 1, ABD_LO - 1, 0);
      add_row(OP_UPDATE, 39, JNT_HI + 1, JNT_HI + 5 * Q_ONE, JNT_HI + 5 * Q_ONE,
              16'hffff, 16'hffff, 1, JNT_HI + 1, 0);
      // first non-joint dimension, angles on a bound, pull back into range
      add_row(OP_UPDATE, 40, JNT_HI + 1, JNT_HI + 5 * Q_ONE, JNT_HI + 5 * Q_ONE,
              16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 1, ABD_HI, ABD_HI + 5 * Q_ONE, ABD_HI + 5 * Q_ONE,
              16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 2, JNT_LO, JNT_LO - 5 * Q_ONE, JNT_LO - 5 * Q_ONE,
              16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 5, ABD_LO - 1, ABD_LO + 5 * Q_ONE, ABD_LO + 5 * Q_ONE,
              16'hffff, 16'hffff, 0, 0, 0);
      // back-to-back on one dimension, then clear it
      add_row(OP_UPDATE, 45, 0, Q_ONE, Q_ONE, 16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 45, 0, Q_ONE, -Q_ONE, 16'h8000, 16'h0001, 0, 0, 0);
      add_row(OP_CLEAR, 45, 32'sh123, 0, 0, 0, 0, 1, 32'sh123, 0);
      add_row(OP_UPDATE, 45, 32'sh123, 32'sh123, 32'sh123, 16'hffff, 16'hffff,
              1, 32'sh123, 0);
      // saturation of velocity and position
      add_row(OP_UPDATE, 53, Q_MAX, Q_MIN, Q_MIN, 16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 53, Q_MIN, Q_MIN, Q_MIN, 16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 52, Q_MIN, Q_MAX, Q_MAX, 16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 46, 0, Q_MAX, Q_MIN, 0, 0, 1, 0, 0);
      add_row(OP_UPDATE, 50, Q_MAX, Q_MAX, Q_MAX, 16'hffff, 16'hffff, 1, Q_MAX, 0);
      // indexes past the store keep nothing
      add_row(OP_UPDATE, 63, 7 * Q_ONE, 0, 0, 16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_UPDATE, 63, 7 * Q_ONE, 0, 0, 16'hffff, 16'hffff, 0, 0, 0);
      add_row(OP_CLEAR, 63, -Q_ONE, 0, 0, 0, 0, 1, -Q_ONE, 0);
      add_row(OP_UPDATE, 54, Q_MIN, Q_MAX, Q_MIN, 16'h1234, 16'hfedc, 0, 0, 0);

      // synchronous reset, released on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].m);
      drain();

      // random phases, each with its own gains and one of four idle patterns
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = IDLE_HEAVY;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = IDLE_HEAVY;
            end
            default: begin
               send_idle_pct = IDLE_LIGHT;
               stall_pct = IDLE_LIGHT;
            end
         endcase
         write_csr(CSR_INERTIA, gain_set[ph][0]);
         write_csr(CSR_COGNITIVE, gain_set[ph][1]);
         write_csr(CSR_SOCIAL, gain_set[ph][2]);
         csr_valid = 1'b0;
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (k == PHASE_WORDS / 2) drain();
            send_word(random_word(), 1'b0, no_move);
         end
         drain();
      end

      stall_pct = 0;
      repeat (20) @(negedge clock);
      $display("sent %0d words (%0d clears, %0d joint-limit stops), checked %0d results",
               n_words, n_clears, n_cuts, n_checked);
      $display("covered reset gains plus %0d written settings under four idle patterns",
               NUM_PHASES);
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
